// ----- hw/rtl/frc_pkg.sv -----
// shared types and constants for the fragment reassembly block
package frc_pkg;

	// packet lead characters
	localparam logic [7:0] LEAD_SENSOR   = 8'h73; // 's'
	localparam logic [7:0] LEAD_DISC_TOP = 8'h77; // 'w'
	localparam logic [7:0] LEAD_DISC_LFT = 8'h61; // 'a'
	localparam logic [7:0] LEAD_DISC_BOT = 8'h78; // 'x'
	localparam logic [7:0] LEAD_DISC_RGT = 8'h64; // 'd'
	localparam logic [7:0] LEAD_FRAG_TOP = 8'h74; // 't'
	localparam logic [7:0] LEAD_FRAG_LFT = 8'h6c; // 'l'
	localparam logic [7:0] LEAD_FRAG_BOT = 8'h62; // 'b'
	localparam logic [7:0] LEAD_FRAG_RGT = 8'h72; // 'r'
	localparam logic [7:0] DIGIT_ZERO    = 8'h30; // '0'

	// result event codes
	localparam logic [2:0] EV_FRAG    = 3'd0;
	localparam logic [2:0] EV_NOCONF  = 3'd1;
	localparam logic [2:0] EV_CONF    = 3'd2;
	localparam logic [2:0] EV_SENSOR  = 3'd3;
	localparam logic [2:0] EV_DISC    = 3'd4;
	localparam logic [2:0] EV_UNKNOWN = 3'd5;

	// side codes
	localparam logic [1:0] SIDE_TOP = 2'd0;
	localparam logic [1:0] SIDE_LFT = 2'd1;
	localparam logic [1:0] SIDE_BOT = 2'd2;
	localparam logic [1:0] SIDE_RGT = 2'd3;

	// one three-byte chunk, byte 0 in the low bits
	localparam int CHUNK_BITS = 24;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_SHIFT,
		S_EMIT,
		S_POST
	} state_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [1:0] side;
		logic [2:0] chunk_index;
		logic [7:0] data_a;
		logic [7:0] data_b;
		logic [7:0] data_c;
		logic [3:0] connect_mask;
		logic       last_of_run;
	} res_t;

endpackage

// ----- hw/rtl/frc_in_if.sv -----
// packet request channel
interface frc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] lead_byte;
	logic [7:0] fragment_digit;
	logic [7:0] payload_a;
	logic [7:0] payload_b;
	logic [7:0] payload_c;

	modport source (
		output valid, lead_byte, fragment_digit, payload_a, payload_b, payload_c,
		input  ready
	);
	modport sink (
		input  valid, lead_byte, fragment_digit, payload_a, payload_b, payload_c,
		output ready
	);
endinterface

// ----- hw/rtl/frc_out_if.sv -----
// result request channel
interface frc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [1:0] side;
	logic [2:0] chunk_index;
	logic [7:0] data_a;
	logic [7:0] data_b;
	logic [7:0] data_c;
	logic [3:0] connect_mask;
	logic       last_of_run;

	modport source (
		output valid, event_res, side, chunk_index, data_a, data_b, data_c,
		       connect_mask, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, event_res, side, chunk_index, data_a, data_b, data_c,
		       connect_mask, last_of_run,
		output ready
	);
endinterface

// ----- hw/rtl/frc_ram.sv -----
// generic single-write, single-read ram with registered read data
module frc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 20
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

// ----- hw/rtl/frc_out.sv -----
// result output register, parts the sequencer from the result sink
module frc_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  frc_pkg::res_t   res,
	output logic            free,
	frc_out_if.source       rsp
);

	logic          vld_q;
	frc_pkg::res_t res_q;

	// slot is free when empty or being drained this cycle
	assign free = !vld_q || rsp.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (rsp.ready) begin
			vld_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign rsp.valid        = vld_q;
	assign rsp.event_res    = res_q.event_res;
	assign rsp.side         = res_q.side;
	assign rsp.chunk_index  = res_q.chunk_index;
	assign rsp.data_a       = res_q.data_a;
	assign rsp.data_b       = res_q.data_b;
	assign rsp.data_c       = res_q.data_c;
	assign rsp.connect_mask = res_q.connect_mask;
	assign rsp.last_of_run  = res_q.last_of_run;

	// a loaded result must not overwrite one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!vld_q || rsp.ready))
		else $error("result register overwritten while stalled");

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && !rsp.ready) |=> (vld_q && $stable(res_q)))
		else $error("stalled result changed");

	// nothing is lost: an unloaded, drained register goes empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && rsp.ready && !load) |=> !vld_q)
		else $error("drained result still valid");

endmodule

// ----- hw/rtl/fragment_reassembly_repeat_confirm.sv -----
// fragment reassembly with repeat confirmation: sequencer, message and history rams
//
//  channel | dir | payload                                         | handshake
//  pkt     | in  | lead_byte fragment_digit payload_a/b/c           | valid/ready
//  rsp     | out | event_res side chunk_index data_a/b/c           | valid/ready
//          |     | connect_mask last_of_run                        |
//
// sequence: one-result packets pass through the post step; a fragment that fills the
//   mask adds a compare pass, then a shift pass and one result, or FRAGMENT_COUNT chunks.
// reset: ram contents are masked by per-entry valid bits, no clearing pass.
// stalls: a stalled result holds the sequencer in its emit or post step;
//   a new packet is taken as soon as the sequencer is idle.
module fragment_reassembly_repeat_confirm #(
	parameter int FRAGMENT_COUNT = 5,
	parameter int MESSAGE_BYTES  = 15
) (
	input  logic      clk,
	input  logic      arst_n,
	frc_in_if.sink    pkt,
	frc_out_if.source rsp
);

	localparam int FC        = FRAGMENT_COUNT;
	localparam int MSG_DEPTH = 4 * FC;
	localparam int MAW       = $clog2(MSG_DEPTH);
	localparam int HAW       = (FC > 1) ? $clog2(FC) : 1;
	localparam int CW        = $clog2(FC + 1);
	localparam int CB        = frc_pkg::CHUNK_BITS;
	localparam logic [FC-1:0] FULL_MASK = '1;
	localparam logic [7:0]    DIGIT_END = frc_pkg::DIGIT_ZERO + 8'(FC);

	frc_pkg::state_t state_q, state_d;

	logic [1:0]      sd_q, sd_d;
	logic [2:0]      ev_q, ev_d;
	logic [1:0]      side_q, side_d;
	logic [CB-1:0]   dat_q, dat_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            match_q, match_d;
	logic [3:0][FC-1:0] mask_q;
	logic [3:0]      connect_q;
	logic [MSG_DEPTH-1:0] msg_vld_q;
	logic [FC-1:0]   hist_vld_q;

	logic            rdv_s1;
	logic [HAW-1:0]  idx_s1;
	logic            vmsg_s1;
	logic            vhist_s1;

	// lead decode
	logic            is_sensor, is_disc, is_frag;
	logic [1:0]      lead_side;
	logic            dig_ok;
	logic [HAW-1:0]  slot;
	logic [FC-1:0]   new_mask;

	// sequencer outputs
	logic            mask_we;
	logic [FC-1:0]   mask_wd;
	logic            connect_set;
	logic            rd_issue;
	logic            rd_take;
	logic            load;
	frc_pkg::res_t   res;
	logic            out_free;

	// ram ports
	logic            msg_we;
	logic [MAW-1:0]  msg_waddr, msg_raddr;
	logic [CB-1:0]   msg_rdata;
	logic            hist_we;
	logic [HAW-1:0]  hist_raddr;
	logic [2*CB-1:0] hist_wdata, hist_rdata;

	// read data after valid masking
	logic [CB-1:0]   msg_chunk, newer, older;

	// zero the bytes of a chunk that lie past the message end
	function automatic logic [CB-1:0] chunk_mask(logic [CB-1:0] d, logic [HAW-1:0] k);
		logic [CB-1:0] r;
		r = d;
		for (int b = 0; b < 3; b++) begin
			if (int'(k) * 3 + b >= MESSAGE_BYTES) begin
				r[b*8 +: 8] = 8'h00;
			end
		end
		return r;
	endfunction

	assign pkt.ready = (state_q == frc_pkg::S_IDLE);

	// lead character decode
	always_comb begin
		is_sensor = 1'b0;
		is_disc   = 1'b0;
		is_frag   = 1'b0;
		lead_side = frc_pkg::SIDE_TOP;
		case (pkt.lead_byte)
			frc_pkg::LEAD_SENSOR:   is_sensor = 1'b1;
			frc_pkg::LEAD_DISC_TOP: begin is_disc = 1'b1; lead_side = frc_pkg::SIDE_TOP; end
			frc_pkg::LEAD_DISC_LFT: begin is_disc = 1'b1; lead_side = frc_pkg::SIDE_LFT; end
			frc_pkg::LEAD_DISC_BOT: begin is_disc = 1'b1; lead_side = frc_pkg::SIDE_BOT; end
			frc_pkg::LEAD_DISC_RGT: begin is_disc = 1'b1; lead_side = frc_pkg::SIDE_RGT; end
			frc_pkg::LEAD_FRAG_TOP: begin is_frag = 1'b1; lead_side = frc_pkg::SIDE_TOP; end
			frc_pkg::LEAD_FRAG_LFT: begin is_frag = 1'b1; lead_side = frc_pkg::SIDE_LFT; end
			frc_pkg::LEAD_FRAG_BOT: begin is_frag = 1'b1; lead_side = frc_pkg::SIDE_BOT; end
			frc_pkg::LEAD_FRAG_RGT: begin is_frag = 1'b1; lead_side = frc_pkg::SIDE_RGT; end
			default: ;
		endcase
	end

	// fragment slot and updated mask
	assign dig_ok   = (pkt.fragment_digit >= frc_pkg::DIGIT_ZERO) &&
	                  (pkt.fragment_digit < DIGIT_END);
	assign slot     = HAW'(pkt.fragment_digit - frc_pkg::DIGIT_ZERO);
	assign new_mask = ((slot == '0) ? '0 : mask_q[lead_side]) | (FC'(1) << slot);

	// ram addressing
	assign msg_waddr  = MAW'(lead_side) * MAW'(FC) + MAW'(slot);
	assign msg_raddr  = MAW'(sd_q) * MAW'(FC) + MAW'(cnt_q);
	assign hist_raddr = HAW'(cnt_q);

	// masked read data
	assign msg_chunk  = vmsg_s1 ? chunk_mask(msg_rdata, idx_s1) : '0;
	assign newer      = vhist_s1 ? hist_rdata[CB-1:0] : '0;
	assign older      = vhist_s1 ? hist_rdata[2*CB-1:CB] : '0;
	assign hist_wdata = {newer, msg_chunk};

	// next state and sequencer outputs
	always_comb begin
		state_d     = state_q;
		sd_d        = sd_q;
		ev_d        = ev_q;
		side_d      = side_q;
		dat_d       = dat_q;
		cnt_d       = cnt_q;
		match_d     = match_q;
		mask_we     = 1'b0;
		mask_wd     = new_mask;
		connect_set = 1'b0;
		msg_we      = 1'b0;
		hist_we     = 1'b0;
		rd_issue    = 1'b0;
		rd_take     = 1'b0;
		load        = 1'b0;
		res         = '0;
		case (state_q)
			frc_pkg::S_IDLE: begin
				if (pkt.valid) begin
					dat_d   = '0;
					side_d  = frc_pkg::SIDE_TOP;
					state_d = frc_pkg::S_POST;
					if (is_sensor) begin
						ev_d  = frc_pkg::EV_SENSOR;
						dat_d = {pkt.payload_b, pkt.payload_a, pkt.fragment_digit};
					end else if (is_disc) begin
						ev_d   = frc_pkg::EV_DISC;
						side_d = lead_side;
					end else if (is_frag) begin
						sd_d   = lead_side;
						side_d = lead_side;
						if (!dig_ok) begin
							ev_d = frc_pkg::EV_UNKNOWN;
						end else begin
							msg_we  = 1'b1;
							mask_we = 1'b1;
							if (new_mask == FULL_MASK) begin
								cnt_d   = '0;
								match_d = 1'b1;
								state_d = frc_pkg::S_CMP;
							end else begin
								ev_d = frc_pkg::EV_FRAG;
							end
						end
					end else begin
						ev_d = frc_pkg::EV_UNKNOWN;
					end
				end
			end
			frc_pkg::S_CMP: begin
				rd_issue = (cnt_q < CW'(FC));
				rd_take  = rdv_s1;
				if (rd_issue) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (rdv_s1) begin
					match_d = match_q && (msg_chunk == newer) && (newer == older) &&
					          ((idx_s1 != '0) || (msg_chunk[7:0] != 8'h00));
				end
				if (!rd_issue && !rdv_s1) begin
					cnt_d = '0;
					if (match_q) begin
						mask_we     = 1'b1;
						mask_wd     = '0;
						connect_set = 1'b1;
						state_d     = frc_pkg::S_EMIT;
					end else begin
						state_d = frc_pkg::S_SHIFT;
					end
				end
			end
			frc_pkg::S_SHIFT: begin
				rd_issue = (cnt_q < CW'(FC));
				rd_take  = rdv_s1;
				if (rd_issue) begin
					cnt_d = cnt_q + 1'b1;
				end
				hist_we = rdv_s1;
				if (!rd_issue && !rdv_s1) begin
					ev_d    = frc_pkg::EV_NOCONF;
					side_d  = sd_q;
					dat_d   = '0;
					state_d = frc_pkg::S_POST;
				end
			end
			frc_pkg::S_EMIT: begin
				rd_take  = rdv_s1 && out_free;
				rd_issue = (cnt_q < CW'(FC)) && (!rdv_s1 || rd_take);
				if (rd_issue) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (rd_take) begin
					load             = 1'b1;
					res.event_res    = frc_pkg::EV_CONF;
					res.side         = sd_q;
					res.chunk_index  = 3'(idx_s1);
					res.data_a       = msg_chunk[7:0];
					res.data_b       = msg_chunk[15:8];
					res.data_c       = msg_chunk[23:16];
					res.connect_mask = connect_q;
					res.last_of_run  = (idx_s1 == HAW'(FC - 1));
					if (idx_s1 == HAW'(FC - 1)) begin
						state_d = frc_pkg::S_IDLE;
					end
				end
			end
			frc_pkg::S_POST: begin
				if (out_free) begin
					load             = 1'b1;
					res.event_res    = ev_q;
					res.side         = side_q;
					res.chunk_index  = '0;
					res.data_a       = dat_q[7:0];
					res.data_b       = dat_q[15:8];
					res.data_c       = dat_q[23:16];
					res.connect_mask = connect_q;
					res.last_of_run  = 1'b1;
					state_d          = frc_pkg::S_IDLE;
				end
			end
			default: state_d = frc_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers, masks, connect bits and ram valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			match_q    <= 1'b0;
			mask_q     <= '0;
			connect_q  <= '0;
			msg_vld_q  <= '0;
			hist_vld_q <= '0;
			rdv_s1     <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			match_q <= match_d;
			rdv_s1  <= rd_issue || (rdv_s1 && !rd_take);
			if (mask_we) begin
				mask_q[(state_q == frc_pkg::S_IDLE) ? lead_side : sd_q] <= mask_wd;
			end
			if (connect_set) begin
				connect_q <= connect_q | (4'b0001 << sd_q);
			end
			if (msg_we) begin
				msg_vld_q[msg_waddr] <= 1'b1;
			end
			if (hist_we) begin
				hist_vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	// payload registers and read tags
	always_ff @(posedge clk) begin
		sd_q   <= sd_d;
		ev_q   <= ev_d;
		side_q <= side_d;
		dat_q  <= dat_d;
		if (rd_issue) begin
			idx_s1   <= HAW'(cnt_q);
			vmsg_s1  <= msg_vld_q[msg_raddr];
			vhist_s1 <= hist_vld_q[HAW'(cnt_q)];
		end
	end

	// message store: four sides of FRAGMENT_COUNT chunks
	frc_ram #(
		.WIDTH (CB),
		.DEPTH (MSG_DEPTH)
	) u_msg_ram (
		.clk   (clk),
		.we    (msg_we),
		.waddr (msg_waddr),
		.wdata ({pkt.payload_c, pkt.payload_b, pkt.payload_a}),
		.re    (rd_issue),
		.raddr (msg_raddr),
		.rdata (msg_rdata)
	);

	// history: newer in the low half, older in the high half
	frc_ram #(
		.WIDTH (2 * CB),
		.DEPTH (FC)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (idx_s1),
		.wdata (hist_wdata),
		.re    (rd_issue),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	frc_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.res    (res),
		.free   (out_free),
		.rsp    (rsp)
	);

	// the compare pass only runs for a side whose mask is full
	a_cmp_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frc_pkg::S_CMP) |-> (mask_q[sd_q] == FULL_MASK))
		else $error("compare pass on a side with an incomplete mask");

	// chunks go out only after the side is marked connected and its mask cleared
	a_emit_conn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frc_pkg::S_EMIT) |-> (connect_q[sd_q] && (mask_q[sd_q] == '0)))
		else $error("emitting chunks for an unconfirmed side");

	// no ram read is in flight outside the passes
	a_no_stray_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frc_pkg::S_IDLE || state_q == frc_pkg::S_POST) |-> !rdv_s1)
		else $error("ram read left in flight");

	// the last confirmed chunk carries the last index
	a_last_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(load && res.event_res == frc_pkg::EV_CONF && res.last_of_run) |->
		(res.chunk_index == 3'(FC - 1)))
		else $error("last confirmed chunk has a wrong index");

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the fragment reassembly block with repeat confirmation
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAG_SLOTS = 5;
	localparam int MSG_BYTES  = 15;
	localparam int SIDES      = 4;
	localparam logic [FRAG_SLOTS-1:0] FULL_MASK = '1;
	localparam int PLAN_PACKETS   = 260;
	localparam int STALL_LIMIT    = 4000;
	localparam int DRAIN_CYCLES   = 24;

	typedef struct {
		logic [7:0] lead;
		logic [7:0] digit;
		logic [7:0] pay_a;
		logic [7:0] pay_b;
		logic [7:0] pay_c;
	} packet_t;

	typedef logic [7:0] msg_t [MSG_BYTES];

	// predicts the results of each packet and checks the block against them
	class reassembly_tracker;
		logic [7:0] msg_store [SIDES][MSG_BYTES];
		logic [FRAG_SLOTS-1:0] frag_mask [SIDES];
		logic [7:0] hist_newer [MSG_BYTES];
		logic [7:0] hist_older [MSG_BYTES];
		logic [3:0] linked_sides;
		frc_pkg::res_t expected_results [$];
		int mismatches;
		int confirmed_msgs;
		int rejected_checks;
		int results_seen;

		function new();
			foreach (msg_store[s, b]) msg_store[s][b] = '0;
			foreach (frag_mask[s]) frag_mask[s] = '0;
			foreach (hist_newer[b]) begin
				hist_newer[b] = '0;
				hist_older[b] = '0;
			end
			linked_sides = '0;
			mismatches = 0;
			confirmed_msgs = 0;
			rejected_checks = 0;
			results_seen = 0;
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		function int pending();
			return expected_results.size();
		endfunction

		// work out the results of one accepted packet
		function void note_packet(packet_t p);
			frc_pkg::res_t r;
			logic [1:0] sd;
			int slot;
			int idx;
			bit same;

			r = '0;
			r.last_of_run = 1'b1;
			r.connect_mask = linked_sides;
			case (p.lead)
				frc_pkg::LEAD_SENSOR: begin
					r.event_res = frc_pkg::EV_SENSOR;
					r.data_a = p.digit;
					r.data_b = p.pay_a;
					r.data_c = p.pay_b;
					expected_results.push_back(r);
					return;
				end
				frc_pkg::LEAD_DISC_TOP, frc_pkg::LEAD_DISC_LFT,
				frc_pkg::LEAD_DISC_BOT, frc_pkg::LEAD_DISC_RGT: begin
					r.event_res = frc_pkg::EV_DISC;
					r.side = (p.lead == frc_pkg::LEAD_DISC_TOP) ? frc_pkg::SIDE_TOP :
						(p.lead == frc_pkg::LEAD_DISC_LFT) ? frc_pkg::SIDE_LFT :
						(p.lead == frc_pkg::LEAD_DISC_BOT) ? frc_pkg::SIDE_BOT :
						frc_pkg::SIDE_RGT;
					expected_results.push_back(r);
					return;
				end
				frc_pkg::LEAD_FRAG_TOP: sd = frc_pkg::SIDE_TOP;
				frc_pkg::LEAD_FRAG_LFT: sd = frc_pkg::SIDE_LFT;
				frc_pkg::LEAD_FRAG_BOT: sd = frc_pkg::SIDE_BOT;
				frc_pkg::LEAD_FRAG_RGT: sd = frc_pkg::SIDE_RGT;
				default: begin
					r.event_res = frc_pkg::EV_UNKNOWN;
					expected_results.push_back(r);
					return;
				end
			endcase

			// digit outside the slot range: nothing stored
			r.side = sd;
			if (p.digit < frc_pkg::DIGIT_ZERO ||
					p.digit >= frc_pkg::DIGIT_ZERO + FRAG_SLOTS) begin
				r.event_res = frc_pkg::EV_UNKNOWN;
				expected_results.push_back(r);
				return;
			end

			// store the fragment, slot zero restarts the mask
			slot = int'(p.digit) - int'(frc_pkg::DIGIT_ZERO);
			if (slot == 0)
				frag_mask[sd] = '0;
			for (int k = 0; k < 3; k++) begin
				idx = slot * 3 + k;
				if (idx < MSG_BYTES)
					msg_store[sd][idx] = (k == 0) ? p.pay_a : (k == 1) ? p.pay_b : p.pay_c;
			end
			frag_mask[sd] = (frag_mask[sd] | FRAG_SLOTS'(1 << slot)) & FULL_MASK;

			if (frag_mask[sd] != FULL_MASK) begin
				r.event_res = frc_pkg::EV_FRAG;
				expected_results.push_back(r);
				return;
			end

			// full message: confirmed when it repeats the last two candidates and its first byte is nonzero
			same = (msg_store[sd][0] != 8'd0);
			for (int b = 0; b < MSG_BYTES; b++)
				if (msg_store[sd][b] != hist_newer[b] || hist_newer[b] != hist_older[b])
					same = 1'b0;

			if (same) begin
				frag_mask[sd] = '0;
				linked_sides = linked_sides | 4'(1 << sd);
				confirmed_msgs++;
				for (int c = 0; c < FRAG_SLOTS; c++) begin
					r = '0;
					r.event_res = frc_pkg::EV_CONF;
					r.side = sd;
					r.chunk_index = 3'(c);
					r.data_a = (c * 3 < MSG_BYTES) ? msg_store[sd][c * 3] : 8'd0;
					r.data_b = (c * 3 + 1 < MSG_BYTES) ? msg_store[sd][c * 3 + 1] : 8'd0;
					r.data_c = (c * 3 + 2 < MSG_BYTES) ? msg_store[sd][c * 3 + 2] : 8'd0;
					r.connect_mask = linked_sides;
					r.last_of_run = (c == FRAG_SLOTS - 1);
					expected_results.push_back(r);
				end
				return;
			end

			// not confirmed: history shifts
			for (int b = 0; b < MSG_BYTES; b++) begin
				hist_older[b] = hist_newer[b];
				hist_newer[b] = msg_store[sd][b];
			end
			rejected_checks++;
			r.event_res = frc_pkg::EV_NOCONF;
			expected_results.push_back(r);
		endfunction

		task compare_field(string name, int got, int want);
			if (got != want)
				report($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		// compare one result from the block with the oldest prediction
		task check_result(frc_pkg::res_t got);
			frc_pkg::res_t want;
			results_seen++;
			if (expected_results.size() == 0) begin
				report($sformatf("result with nothing pending, event %0d", got.event_res));
			end else begin
				want = expected_results.pop_front();
				compare_field("event_res", got.event_res, want.event_res);
				compare_field("side", got.side, want.side);
				compare_field("chunk_index", got.chunk_index, want.chunk_index);
				compare_field("data_a", got.data_a, want.data_a);
				compare_field("data_b", got.data_b, want.data_b);
				compare_field("data_c", got.data_c, want.data_c);
				compare_field("connect_mask", got.connect_mask, want.connect_mask);
				compare_field("last_of_run", got.last_of_run, want.last_of_run);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	frc_in_if  pkt();
	frc_out_if rsp();

	reassembly_tracker board = new();
	packet_t packet_plan [$];
	int packets_sent;

	fragment_reassembly_repeat_confirm u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.rsp    (rsp)
	);

	// clock and reset
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// stimulus building blocks
	function automatic logic [7:0] lead_of_side(int sd);
		case (sd)
			0: return frc_pkg::LEAD_FRAG_TOP;
			1: return frc_pkg::LEAD_FRAG_LFT;
			2: return frc_pkg::LEAD_FRAG_BOT;
			default: return frc_pkg::LEAD_FRAG_RGT;
		endcase
	endfunction

	function automatic void add_packet(logic [7:0] lead, logic [7:0] digit,
			logic [7:0] a, logic [7:0] b, logic [7:0] c);
		packet_t p;
		p.lead = lead;
		p.digit = digit;
		p.pay_a = a;
		p.pay_b = b;
		p.pay_c = c;
		packet_plan.push_back(p);
	endfunction

	function automatic void add_slot(int sd, msg_t msg, int slot);
		add_packet(lead_of_side(sd), frc_pkg::DIGIT_ZERO + 8'(slot),
			msg[slot * 3], msg[slot * 3 + 1], msg[slot * 3 + 2]);
	endfunction

	function automatic void random_message(output msg_t msg, input bit zero_head);
		foreach (msg[b]) msg[b] = 8'($urandom_range(255));
		msg[0] = zero_head ? 8'd0 : 8'($urandom_range(255, 1));
	endfunction

	function automatic logic [7:0] bad_digit();
		if ($urandom_range(1))
			return 8'($urandom_range(frc_pkg::DIGIT_ZERO - 1, 0));
		return 8'($urandom_range(255, frc_pkg::DIGIT_ZERO + FRAG_SLOTS));
	endfunction

	// packets that never store a fragment, plus stray fragments when allowed
	function automatic void add_noise(bit allow_frag);
		logic [7:0] lead;
		case ($urandom_range(allow_frag ? 4 : 3))
			0: add_packet(frc_pkg::LEAD_SENSOR, 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
			1: begin
				case ($urandom_range(3))
					0: lead = frc_pkg::LEAD_DISC_TOP;
					1: lead = frc_pkg::LEAD_DISC_LFT;
					2: lead = frc_pkg::LEAD_DISC_BOT;
					default: lead = frc_pkg::LEAD_DISC_RGT;
				endcase
				add_packet(lead, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end
			2: begin
				lead = 8'($urandom_range(255));
				if (lead == frc_pkg::LEAD_FRAG_TOP || lead == frc_pkg::LEAD_FRAG_LFT ||
						lead == frc_pkg::LEAD_FRAG_BOT || lead == frc_pkg::LEAD_FRAG_RGT)
					add_packet(lead, bad_digit(), 8'($urandom), 8'($urandom), 8'($urandom));
				else
					add_packet(lead, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end
			3: add_packet(lead_of_side($urandom_range(3)), bad_digit(),
				8'($urandom), 8'($urandom), 8'($urandom));
			default: add_packet(lead_of_side($urandom_range(3)),
				frc_pkg::DIGIT_ZERO + 8'($urandom_range(FRAG_SLOTS - 1)),
				8'($urandom), 8'($urandom), 8'($urandom));
		endcase
	endfunction

	// whole message: slot zero first, the rest in random order
	function automatic void add_message(int sd, msg_t msg, bit noisy);
		int order [FRAG_SLOTS];
		int j;
		int t;
		foreach (order[k]) order[k] = k;
		for (int k = FRAG_SLOTS - 1; k > 1; k--) begin
			j = $urandom_range(k, 1);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		foreach (order[k]) begin
			add_slot(sd, msg, order[k]);
			if (noisy && $urandom_range(99) < 15)
				add_noise(1'b0);
		end
	endfunction

	function automatic void build_directed();
		msg_t msg;
		// sensor extremes, each disconnect, unknown leads
		add_packet(frc_pkg::LEAD_SENSOR, 8'h00, 8'h00, 8'h00, 8'h00);
		add_packet(frc_pkg::LEAD_SENSOR, 8'hff, 8'hff, 8'hff, 8'hff);
		add_packet(frc_pkg::LEAD_DISC_TOP, 8'h00, 8'h00, 8'h00, 8'h00);
		add_packet(frc_pkg::LEAD_DISC_LFT, 8'hff, 8'hff, 8'hff, 8'hff);
		add_packet(frc_pkg::LEAD_DISC_BOT, 8'h00, 8'h00, 8'h00, 8'h00);
		add_packet(frc_pkg::LEAD_DISC_RGT, 8'hff, 8'hff, 8'hff, 8'hff);
		add_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		add_packet(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		// digits just outside the slot range and far off
		add_packet(frc_pkg::LEAD_FRAG_TOP, frc_pkg::DIGIT_ZERO - 8'd1, 8'hff, 8'hff, 8'hff);
		add_packet(frc_pkg::LEAD_FRAG_LFT, frc_pkg::DIGIT_ZERO + 8'(FRAG_SLOTS),
			8'hff, 8'hff, 8'hff);
		add_packet(frc_pkg::LEAD_FRAG_BOT, 8'hff, 8'h00, 8'h00, 8'h00);
		// top message, then two rewrites rerun the check on the full mask
		foreach (msg[b]) msg[b] = 8'(8'h5a + 8'h11 * b);
		for (int s = 0; s < FRAG_SLOTS; s++)
			add_slot(frc_pkg::SIDE_TOP, msg, s);
		add_slot(frc_pkg::SIDE_TOP, msg, 2);
		add_slot(frc_pkg::SIDE_TOP, msg, FRAG_SLOTS - 1);
		// mask is clear again after the confirmation
		add_slot(frc_pkg::SIDE_TOP, msg, 1);
		// repeated message with a zero first byte never confirms
		random_message(msg, 1'b1);
		for (int s = 0; s < FRAG_SLOTS; s++)
			add_slot(frc_pkg::SIDE_LFT, msg, s);
		add_slot(frc_pkg::SIDE_LFT, msg, 3);
		add_slot(frc_pkg::SIDE_LFT, msg, 1);
	endfunction

	function automatic void build_random(int target);
		msg_t msg;
		msg_t other;
		int sd;
		int pick;
		while (packet_plan.size() < target) begin
			sd = $urandom_range(SIDES - 1);
			pick = $urandom_range(99);
			if (pick < 45) begin
				// confirm through rewrites of slots other than zero
				random_message(msg, $urandom_range(19) == 0);
				add_message(sd, msg, 1'b1);
				repeat ($urandom_range(3, 2)) begin
					if ($urandom_range(99) < 15)
						add_noise(1'b0);
					add_slot(sd, msg, $urandom_range(FRAG_SLOTS - 1, 1));
				end
			end else if (pick < 65) begin
				// the same full message three times
				random_message(msg, 1'b0);
				repeat (3) add_message(sd, msg, 1'b1);
			end else if (pick < 75) begin
				// broken run: content changes between candidates
				random_message(msg, 1'b0);
				random_message(other, $urandom_range(1));
				add_message(sd, msg, 1'b0);
				add_message(sd, other, 1'b1);
				add_slot(sd, msg, $urandom_range(FRAG_SLOTS - 1));
				add_slot(sd, other, $urandom_range(FRAG_SLOTS - 1, 1));
			end else begin
				repeat ($urandom_range(4, 1)) add_noise(1'b1);
			end
		end
	endfunction

	function automatic bit take_break(bit quiet);
		return !quiet && ($urandom_range(99) < 37);
	endfunction

	// result side: random back-pressure, every request checked
	initial begin : result_sink
		frc_pkg::res_t got;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready) begin
				got.event_res = rsp.event_res;
				got.side = rsp.side;
				got.chunk_index = rsp.chunk_index;
				got.data_a = rsp.data_a;
				got.data_b = rsp.data_b;
				got.data_c = rsp.data_c;
				got.connect_mask = rsp.connect_mask;
				got.last_of_run = rsp.last_of_run;
				board.check_result(got);
			end
			rsp.ready <= arst_n && !take_break(board.results_seen >= 150 &&
				board.results_seen < 260);
		end
	end

	// ends the run when no request moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pkt.valid === 1'b1 && pkt.ready === 1'b1) ||
					(rsp.valid === 1'b1 && rsp.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout after %0d cycles without a request, %0d results outstanding",
			STALL_LIMIT, board.pending());
		$display("CHECK FAILED");
		$finish;
	end

	// packet side: plan, drive, drain, verdict
	initial begin : packet_source
		int directed_count;
		bit accepted;
		pkt.valid = 1'b0;
		pkt.lead_byte = '0;
		pkt.fragment_digit = '0;
		pkt.payload_a = '0;
		pkt.payload_b = '0;
		pkt.payload_c = '0;
		packets_sent = 0;

		build_directed();
		directed_count = packet_plan.size();
		build_random(PLAN_PACKETS);

		wait (arst_n === 1'b1);
		while (packets_sent < packet_plan.size()) begin
			@(posedge clk);
			accepted = pkt.valid && pkt.ready === 1'b1;
			if (accepted) begin
				board.note_packet(packet_plan[packets_sent]);
				packets_sent++;
			end
			// hold a pending request, otherwise offer the next one or idle
			if (pkt.valid && !accepted) begin
			end else if (packets_sent < packet_plan.size() &&
					!take_break(packets_sent >= 120 && packets_sent < 180)) begin
				pkt.valid <= 1'b1;
				pkt.lead_byte <= packet_plan[packets_sent].lead;
				pkt.fragment_digit <= packet_plan[packets_sent].digit;
				pkt.payload_a <= packet_plan[packets_sent].pay_a;
				pkt.payload_b <= packet_plan[packets_sent].pay_b;
				pkt.payload_c <= packet_plan[packets_sent].pay_c;
			end else begin
				pkt.valid <= 1'b0;
			end
		end

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d packets (%0d directed), %0d results checked",
			packets_sent, directed_count, board.results_seen);
		$display("%0d messages confirmed, %0d full-mask checks rejected, %0d mismatches",
			board.confirmed_msgs, board.rejected_checks, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/frc_pkg.sv
hw/rtl/frc_in_if.sv
hw/rtl/frc_out_if.sv
hw/rtl/frc_ram.sv
hw/rtl/frc_out.sv
hw/rtl/fragment_reassembly_repeat_confirm.sv
bench/tb_top.sv
